// ===== src/ngfc_pkg.sv =====
// ngfc_pkg: shared constants and types of the n-gram frequency counter
// no dependencies; used by ngram_frequency_counter
package ngfc_pkg;

    // default sizes
    localparam int MAX_GRAM_BYTES = 8;
    localparam int TABLE_DEPTH    = 1024;
    localparam int COUNT_WIDTH    = 32;

    // reset value of the gram length register
    localparam logic [3:0] NGRAM_LENGTH_RESET = 4'd3;

    // the newline byte travels as an ordinary byte
    localparam logic [7:0] NEWLINE_BYTE = 8'h0a;

    // operation codes on the input tuser
    typedef enum logic [1:0] {
        FUNC_FEED   = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_NEWSTR = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // control sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_INS,
        ST_SWEEP,
        ST_OUT
    } state_t;

    // one result word before packing
    typedef struct packed {
        logic        valid;
        logic        is_new;
        logic        full;
        logic [9:0]  index;
        logic [31:0] count;
        logic [63:0] bytes;
        logic [10:0] used;
    } result_t;

endpackage

// ===== src/ngram_frequency_counter.sv =====
// ngram_frequency_counter: counts byte n-grams in a key/count table kept in
// first-seen order; depends on ngfc_pkg
//
// Usage: the slave channel takes one word per operation. s_axis_tuser holds
// the operation (feed byte, read entry, new stream, clear all), s_axis_tdata
// the byte and the read index. Every word gives exactly one result word on
// the master channel, with the flags in m_axis_tuser and the index, count,
// gram bytes and table occupancy in m_axis_tdata.
// Operation: the keys and counts sit in two single-port memories with
// registered reads, searched linearly in first-seen order through a read
// and a compare state per held entry. A fed byte that forms a gram walks
// up to the entry it hits, or past all held entries and then appends; a
// byte that does not fill the window, a clear, or a read outside the
// table goes straight out; a new stream clears held counts, one per cycle.
// Reset empties the window and the table and sets the gram length to 3;
// the memories are not swept. The result sits in an output register, so
// the next word is taken while the receiver stalls; a second result then
// waits in the sequencer until the register frees.
// The gram length register may be written only while the block is idle.
module ngram_frequency_counter #(
    parameter int MAX_GRAM_BYTES = ngfc_pkg::MAX_GRAM_BYTES,
    parameter int TABLE_DEPTH    = ngfc_pkg::TABLE_DEPTH,
    parameter int COUNT_WIDTH    = ngfc_pkg::COUNT_WIDTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wen,
    input  logic [3:0]   cfg_wdata,      // ngram_length
    // input words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // data_byte[7:0], read_index[17:8]
    input  logic [1:0]   s_axis_tuser,   // func
    // result words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_index[9:0], gram_count[41:10], gram_bytes[105:42],
    // entries_used[116:106]
    output logic [119:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser    // gram_valid, gram_new, table_full
);

    localparam int KEY_W = 8 * MAX_GRAM_BYTES;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int TOT_W = IDX_W + 1;
    localparam int CMP_W = (TOT_W > 10) ? TOT_W : 10;
    localparam logic [TOT_W-1:0] DEPTH_TOT = TOT_W'(TABLE_DEPTH);
    localparam logic [3:0] MAX_LEN = 4'(MAX_GRAM_BYTES);

    // memories
    logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] cnt_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]       key_q;
    logic [COUNT_WIDTH-1:0] cnt_q;
    logic [IDX_W-1:0]       mem_addr;
    logic                   key_we;
    logic                   cnt_we;
    logic [COUNT_WIDTH-1:0] cnt_wdata;

    // registers
    ngfc_pkg::state_t       state_reg, state_next;
    logic [3:0]             len_reg;
    logic [KEY_W-1:0]       window_reg, window_next;
    logic [3:0]             fill_reg, fill_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [KEY_W-1:0]       gram_reg, gram_next;
    logic                   is_read_reg, is_read_next;
    ngfc_pkg::result_t      res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    ngfc_pkg::result_t      out_reg, out_next;

    // input fields
    ngfc_pkg::func_t        func;
    logic [7:0]             data_byte;
    logic [9:0]             read_index;
    logic                   s_acc;
    logic                   out_free;

    // helper values
    logic [3:0]             eff_len;
    logic [KEY_W-1:0]       shifted;
    logic [3:0]             fill_inc;
    logic [KEY_W-1:0]       gram_new_val;
    logic                   last_entry;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    assign func       = ngfc_pkg::func_t'(s_axis_tuser);
    assign data_byte  = s_axis_tdata[7:0];
    assign read_index = s_axis_tdata[17:8];
    assign s_axis_tready = (state_reg == ngfc_pkg::ST_IDLE);
    assign s_acc      = s_axis_tvalid && s_axis_tready;
    assign out_free   = !out_valid_reg || m_axis_tready;

    // effective gram length, out-of-range values clamped
    always_comb begin
        if (len_reg == 4'd0) begin
            eff_len = 4'd1;
        end else if (len_reg > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = len_reg;
        end
    end

    // window after shifting in the byte, and the masked gram
    always_comb begin
        shifted  = (window_reg << 8) | KEY_W'(data_byte);
        fill_inc = (fill_reg < MAX_LEN) ? fill_reg + 4'd1 : fill_reg;
        for (int k = 0; k < MAX_GRAM_BYTES; k++) begin
            gram_new_val[8*k +: 8] = (4'(k) < eff_len) ? shifted[8*k +: 8] : 8'h00;
        end
    end

    assign last_entry = (TOT_W'(idx_reg) + TOT_W'(1)) == total_reg;
    assign cnt_inc    = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_WIDTH'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ngfc_pkg::ST_IDLE: begin
                if (s_acc) begin
                    unique case (func)
                        ngfc_pkg::FUNC_FEED: begin
                            if (fill_inc < eff_len) begin
                                state_next = ngfc_pkg::ST_OUT;
                            end else if (total_reg == '0) begin
                                state_next = ngfc_pkg::ST_INS;
                            end else begin
                                state_next = ngfc_pkg::ST_RD;
                            end
                        end
                        ngfc_pkg::FUNC_READ: begin
                            if (CMP_W'(read_index) < CMP_W'(total_reg)) begin
                                state_next = ngfc_pkg::ST_RD;
                            end else begin
                                state_next = ngfc_pkg::ST_OUT;
                            end
                        end
                        ngfc_pkg::FUNC_NEWSTR: begin
                            state_next = (total_reg == '0) ? ngfc_pkg::ST_OUT
                                                           : ngfc_pkg::ST_SWEEP;
                        end
                        default: state_next = ngfc_pkg::ST_OUT;
                    endcase
                end
            end
            ngfc_pkg::ST_RD: state_next = ngfc_pkg::ST_CMP;
            ngfc_pkg::ST_CMP: begin
                if (is_read_reg || key_q == gram_reg) begin
                    state_next = ngfc_pkg::ST_OUT;
                end else if (last_entry) begin
                    state_next = ngfc_pkg::ST_INS;
                end else begin
                    state_next = ngfc_pkg::ST_RD;
                end
            end
            ngfc_pkg::ST_INS: state_next = ngfc_pkg::ST_OUT;
            ngfc_pkg::ST_SWEEP: begin
                if (last_entry) begin
                    state_next = ngfc_pkg::ST_OUT;
                end
            end
            ngfc_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = ngfc_pkg::ST_IDLE;
                end
            end
            default: state_next = ngfc_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        window_next    = window_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        gram_next      = gram_reg;
        is_read_next   = is_read_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mem_addr       = idx_reg;
        key_we         = 1'b0;
        cnt_we         = 1'b0;
        cnt_wdata      = cnt_inc;

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ngfc_pkg::ST_IDLE: begin
                if (s_acc) begin
                    res_next      = '0;
                    res_next.used = 11'(total_reg);
                    idx_next      = '0;
                    is_read_next  = (func == ngfc_pkg::FUNC_READ);
                    case (func)
                        ngfc_pkg::FUNC_FEED: begin
                            window_next = shifted;
                            fill_next   = fill_inc;
                            gram_next   = gram_new_val;
                        end
                        ngfc_pkg::FUNC_READ: begin
                            idx_next = IDX_W'(read_index);
                        end
                        ngfc_pkg::FUNC_NEWSTR: begin
                            window_next = '0;
                            fill_next   = '0;
                        end
                        default: begin
                            window_next   = '0;
                            fill_next     = '0;
                            total_next    = '0;
                            res_next.used = '0;
                        end
                    endcase
                end
            end
            ngfc_pkg::ST_CMP: begin
                if (is_read_reg) begin
                    res_next.valid = 1'b1;
                    res_next.index = 10'(idx_reg);
                    res_next.count = 32'(cnt_q);
                    res_next.bytes = 64'(key_q);
                end else if (key_q == gram_reg) begin
                    // hit: saturating increment, written back in place
                    cnt_we         = 1'b1;
                    res_next.valid = 1'b1;
                    res_next.index = 10'(idx_reg);
                    res_next.count = 32'(cnt_inc);
                    res_next.bytes = 64'(gram_reg);
                end else if (!last_entry) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ngfc_pkg::ST_INS: begin
                res_next.bytes = 64'(gram_reg);
                if (total_reg == DEPTH_TOT) begin
                    res_next.full = 1'b1;
                end else begin
                    // append a new gram at the end of the table
                    mem_addr        = total_reg[IDX_W-1:0];
                    key_we          = 1'b1;
                    cnt_we          = 1'b1;
                    cnt_wdata       = COUNT_WIDTH'(1);
                    total_next      = total_reg + TOT_W'(1);
                    res_next.valid  = 1'b1;
                    res_next.is_new = 1'b1;
                    res_next.index  = 10'(total_reg);
                    res_next.count  = 32'd1;
                    res_next.used   = 11'(total_reg + TOT_W'(1));
                end
            end
            ngfc_pkg::ST_SWEEP: begin
                // zero one count per cycle
                cnt_we    = 1'b1;
                cnt_wdata = '0;
                if (!last_entry) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ngfc_pkg::ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                end
            end
            default: ;
        endcase
    end

    // key and count memories
    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[mem_addr] <= gram_reg;
        end
        key_q <= key_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[mem_addr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[mem_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ngfc_pkg::ST_IDLE;
            len_reg       <= ngfc_pkg::NGRAM_LENGTH_RESET;
            window_reg    <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen) begin
                len_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        gram_reg    <= gram_next;
        is_read_reg <= is_read_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    // result word packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {out_reg.full, out_reg.is_new, out_reg.valid};
    assign m_axis_tdata  = {3'b000, out_reg.used, out_reg.bytes,
                            out_reg.count, out_reg.index};

    // checks
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= DEPTH_TOT)
        else $error("entry total beyond table depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ngfc_pkg::ST_INS && total_reg != DEPTH_TOT)
        |=> total_reg == $past(total_reg) + TOT_W'(1))
        else $error("append did not grow the table by one");

    a_sweep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ngfc_pkg::ST_SWEEP) |-> (TOT_W'(idx_reg) < total_reg))
        else $error("count sweep beyond held entries");

    a_busy_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ngfc_pkg::ST_CMP || state_reg == ngfc_pkg::ST_SWEEP)
        |-> !s_axis_tready)
        else $error("word taken during table walk");

endmodule
